/* design/hfir_pkg.sv */
// Shared types and constants for the Hilbert FIR I/Q splitter.
// Used by the ring cells, the ring, the multiply-accumulate unit and the top level.
// No dependencies.
package hfir_pkg;

    localparam int TAPS        = 255;
    localparam int COEFF_BITS  = 18;
    localparam int SAMPLE_W    = 32;
    localparam int IDX_W       = 8;
    localparam int GROUP_DELAY = (TAPS - 1) / 2;
    localparam int PROD_W      = SAMPLE_W + COEFF_BITS;
    localparam int CNT_W       = $clog2(TAPS);
    localparam int ACC_W       = PROD_W + $clog2(TAPS + 1);
    localparam int RSHIFT      = COEFF_BITS - 1;

    localparam logic [ACC_W-1:0]    RND_ADD = ACC_W'(1) << (RSHIFT - 1);
    localparam logic [SAMPLE_W-1:0] Q_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] Q_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic shift_in;
        logic rotate;
        logic load;
    } t_ring_ctrl;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } t_mac_ctrl;

endpackage

/* design/hfir_cell.sv */
// One cell of the history/coefficient ring: holds one sample and one tap.
// Depends on hfir_pkg.
module hfir_cell
    import hfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_hist_en,
    input  logic                  i_coef_en,
    input  logic                  i_load_en,
    input  logic [SAMPLE_W-1:0]   i_hist_prev,
    input  logic [COEFF_BITS-1:0] i_coef_prev,
    input  logic [COEFF_BITS-1:0] i_coef_value,
    output logic [SAMPLE_W-1:0]   o_hist,
    output logic [COEFF_BITS-1:0] o_coef
);

    logic [SAMPLE_W-1:0]   r_hist;
    logic [COEFF_BITS-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_hist_en) begin
                r_hist <= i_hist_prev;
            end
            if (i_load_en) begin
                r_coef <= i_coef_value;
            end else if (i_coef_en) begin
                r_coef <= i_coef_prev;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_coef = r_coef;

endmodule

/* design/hfir_ring.sv */
// Ring of TAPS cells; cell k holds x[n-k] and h[k] while at rest.
// Depends on hfir_pkg and hfir_cell.
module hfir_ring
    import hfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ring_ctrl            i_ctrl,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [IDX_W-1:0]      i_coeff_index,
    input  logic [COEFF_BITS-1:0] i_coeff_value,
    output logic [SAMPLE_W-1:0]   o_head_hist,
    output logic [COEFF_BITS-1:0] o_head_coef,
    output logic [SAMPLE_W-1:0]   o_delay_hist
);

    logic [SAMPLE_W-1:0]   w_hist [TAPS];
    logic [COEFF_BITS-1:0] w_coef [TAPS];
    logic                  w_hist_en;

    assign w_hist_en = i_ctrl.shift_in | i_ctrl.rotate;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic [SAMPLE_W-1:0]   w_hprev;
        logic [COEFF_BITS-1:0] w_cprev;
        logic                  w_load;

        if (k == 0) begin : g_head
            // A new sample enters at the front; during a pass the tail wraps around.
            assign w_hprev = i_ctrl.shift_in ? i_sample : w_hist[TAPS-1];
            assign w_cprev = w_coef[TAPS-1];
        end else begin : g_body
            assign w_hprev = w_hist[k-1];
            assign w_cprev = w_coef[k-1];
        end

        assign w_load = i_ctrl.load && (int'(i_coeff_index) == k);

        hfir_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_hist_en    (w_hist_en),
            .i_coef_en    (i_ctrl.rotate),
            .i_load_en    (w_load),
            .i_hist_prev  (w_hprev),
            .i_coef_prev  (w_cprev),
            .i_coef_value (i_coeff_value),
            .o_hist       (w_hist[k]),
            .o_coef       (w_coef[k])
        );
    end

    assign o_head_hist  = w_hist[TAPS-1];
    assign o_head_coef  = w_coef[TAPS-1];
    assign o_delay_hist = w_hist[GROUP_DELAY];

endmodule

/* design/hfir_mac.sv */
// Shared multiply-accumulate unit with round-half-up and saturation to Q1.31.
// Depends on hfir_pkg.
module hfir_mac
    import hfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mac_ctrl             i_ctrl,
    input  logic [SAMPLE_W-1:0]   i_hist,
    input  logic [COEFF_BITS-1:0] i_coef,
    output logic [SAMPLE_W-1:0]   o_result
);

    logic signed [SAMPLE_W-1:0]   w_x;
    logic signed [COEFF_BITS-1:0] w_h;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_prod_vld;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      w_rnd;
    logic signed [ACC_W-1:0]      w_sh;
    logic [ACC_W-SAMPLE_W:0]      w_top;

    assign w_x    = signed'(i_hist);
    assign w_h    = signed'(i_coef);
    assign w_prod = w_x * w_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign w_rnd = r_acc + signed'(RND_ADD);
    assign w_sh  = w_rnd >>> RSHIFT;
    assign w_top = w_sh[ACC_W-1:SAMPLE_W-1];

    // The value fits when every bit above the Q1.31 range copies its sign.
    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_result = w_sh[SAMPLE_W-1:0];
        end else if (w_sh[ACC_W-1]) begin
            o_result = Q_MIN;
        end else begin
            o_result = Q_MAX;
        end
    end

endmodule

/* design/hilbert_fir_iq_split.sv */
// Top level of the Hilbert FIR I/Q splitter: sequencer, ring of cells, MAC, output register.
// Depends on hfir_pkg, hfir_ring and hfir_mac.
//
//  Channel    Direction  Payload
//  s_axis     in         tuser: opcode; tdata: sample, coeff_index, coeff_value
//  m_axis     out        tdata: quadrature, delayed
//
// A process transaction shifts the sample in, rotates the ring once through the single
// multiplier, drains the product register and rounds into the output register.
// A coefficient load gives no result.
// Reset clears the history, the coefficients and all control state at once.
// A result waiting in the output register stalls only the final rounding step.
module hilbert_fir_iq_split
    import hfir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // sample[31:0], coeff_index[39:32],
                                       // coeff_value[57:40], zeros[63:58]
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // quadrature[31:0], delayed[63:32]
);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [63:0]           r_out_data;
    t_ring_ctrl            w_ring;
    t_mac_ctrl             w_mac;
    logic                  w_out_load;
    logic                  w_last;
    logic [SAMPLE_W-1:0]   w_sample;
    logic [IDX_W-1:0]      w_idx;
    logic [COEFF_BITS-1:0] w_cval;
    logic [SAMPLE_W-1:0]   w_head_hist;
    logic [COEFF_BITS-1:0] w_head_coef;
    logic [SAMPLE_W-1:0]   w_delay_hist;
    logic [SAMPLE_W-1:0]   w_quad;

    assign w_sample = s_axis_tdata[31:0];
    assign w_idx    = s_axis_tdata[39:32];
    assign w_cval   = s_axis_tdata[57:40];
    assign w_last   = (r_cnt == CNT_W'(TAPS - 1));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser == OP_PROCESS) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb begin
        s_axis_tready = 1'b0;
        w_ring        = '0;
        w_mac         = '0;
        w_out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_PROCESS) begin
                        w_ring.shift_in = 1'b1;
                        w_mac.clear     = 1'b1;
                    end else begin
                        w_ring.load = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                w_ring.rotate = 1'b1;
                w_mac.mul_en  = 1'b1;
            end
            ST_FLUSH: begin
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_cnt = '0;
        if (r_state == ST_RUN && !w_last) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // After a full rotation the ring is back at rest, so the delay tap is x[n-D].
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {w_delay_hist, w_quad};
        end
    end

    hfir_ring u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ring),
        .i_sample      (w_sample),
        .i_coeff_index (w_idx),
        .i_coeff_value (w_cval),
        .o_head_hist   (w_head_hist),
        .o_head_coef   (w_head_coef),
        .o_delay_hist  (w_delay_hist)
    );

    hfir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac),
        .i_hist   (w_head_hist),
        .i_coef   (w_head_coef),
        .o_result (w_quad)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD) |=> (r_state == ST_IDLE))
        else $error("coefficient load left the idle state");

    a_process_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_PROCESS)
        |=> (r_state == ST_RUN && r_cnt == '0))
        else $error("process transaction did not start a rotation pass");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared outside the rounding step");

    a_ring_rests_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> (!w_ring.rotate && !w_mac.mul_en))
        else $error("ring rotated outside a pass");

endmodule

/* tb/hilbert_fir_iq_split_tb.sv */
// Self-checking testbench for hilbert_fir_iq_split: directed and random stream traffic.
// A predictor of the Hilbert FIR and group-delay path checks every result transaction.
// Depends on hfir_pkg and the hilbert_fir_iq_split RTL.
`timescale 1ns / 1ps

module hilbert_fir_iq_split_tb
    import hfir_pkg::*;
();

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [31:0] delayed;
        logic [31:0] quadrature;
    } t_iq_pair;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;  // sample[31:0], coeff_index[39:32],
                                      // coeff_value[57:40], zeros[63:58]
    logic        s_axis_tuser  = 1'b0;  // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;  // quadrature[31:0], delayed[63:32]

    // Predictor state: sample history ring, write slot and impulse response.
    logic signed [31:0]           sample_hist [TAPS];
    logic signed [COEFF_BITS-1:0] tap_store   [TAPS];
    int unsigned                  hist_ptr;

    t_iq_pair iq_expected [$];
    int       error_count   = 0;
    int       cycle_count   = 0;
    int       tx_idle_pct   = 35;
    int       rx_idle_pct   = 35;
    int       rx_stall_left = 0;

    hilbert_fir_iq_split uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        end
        error_count++;
    endtask

    // Direct convolution over the history, then round half up and saturate to Q1.31.
    function automatic t_iq_pair hilbert_step(input logic signed [31:0] smp);
        longint      acc;
        int unsigned slot;
        t_iq_pair    res;
        sample_hist[hist_ptr] = smp;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            slot = (hist_ptr + TAPS - k) % TAPS;
            acc += longint'(sample_hist[slot]) * longint'(tap_store[k]);
        end
        acc = (acc + (longint'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
        if (acc > longint'($signed(Q_MAX))) begin
            res.quadrature = Q_MAX;
        end else if (acc < longint'($signed(Q_MIN))) begin
            res.quadrature = Q_MIN;
        end else begin
            res.quadrature = 32'(acc);
        end
        res.delayed = sample_hist[(hist_ptr + TAPS - GROUP_DELAY) % TAPS];
        hist_ptr = (hist_ptr + 1) % TAPS;
        return res;
    endfunction

    function automatic logic [31:0] pick_sample(input int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed(16'($urandom)));
            default: begin
                case ($urandom_range(3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Check each result transaction first, then predict from the input transaction.
    always @(posedge i_clk) begin : scoreboard
        t_iq_pair got;
        t_iq_pair want;
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                sample_hist[k] = '0;
                tap_store[k]   = '0;
            end
            hist_ptr = 0;
            iq_expected.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (iq_expected.size() == 0) begin
                    report_mismatch("result with none pending, quadrature",
                                    got.quadrature, '0);
                end else begin
                    want = iq_expected.pop_front();
                    if (got.quadrature !== want.quadrature)
                        report_mismatch("quadrature", got.quadrature, want.quadrature);
                    if (got.delayed !== want.delayed)
                        report_mismatch("delayed", got.delayed, want.delayed);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_LOAD) begin
                    if (s_axis_tdata[39:32] < TAPS)
                        tap_store[s_axis_tdata[39:32]] = s_axis_tdata[57:40];
                end else begin
                    iq_expected.push_back(hilbert_step(s_axis_tdata[31:0]));
                end
            end
        end
    end

    // Result side: short random stalls with an occasional long one.
    always @(posedge i_clk) begin : sink_ready
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
            m_axis_tready <= 1'b0;
            if ($urandom_range(49) == 0)
                rx_stall_left <= $urandom_range(300, 20);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Leaves tvalid high on return so that the next transaction can follow without a gap.
    task automatic send_item(input logic op, input logic [31:0] smp,
                             input logic [7:0] idx, input logic [17:0] val);
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(19) == 0) ? $urandom_range(300, 20) : $urandom_range(4, 1);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, val, idx, smp};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (iq_expected.size() != 0);
    endtask

    // With all taps at zero the filter gives zero and the delayed path still holds reset zeros.
    task automatic test_start_up();
        send_item(OP_PROCESS, Q_MAX, 8'd0, 18'h3FFFF);
        send_item(OP_PROCESS, Q_MIN, 8'hFF, 18'h00000);
        send_item(OP_PROCESS, 32'h0000_0000, 8'd0, 18'h3FFFF);
        send_item(OP_PROCESS, 32'hFFFF_FFFF, 8'hFF, 18'h00000);
    endtask

    task automatic test_coeff_extremes();
        send_item(OP_LOAD, 32'hFFFF_FFFF, 8'd0, 18'h20000);
        send_item(OP_PROCESS, Q_MIN, 8'd0, 18'h0);
        send_item(OP_PROCESS, Q_MAX, 8'd0, 18'h0);
        send_item(OP_LOAD, 32'h0, 8'd0, 18'h1FFFF);
        send_item(OP_PROCESS, Q_MIN, 8'd0, 18'h0);
        send_item(OP_LOAD, 32'h0, 8'd254, 18'h20000);
    endtask

    // Only the newest sample sees a unit tap, so each result is the sample rounded at the half.
    task automatic test_rounding();
        send_item(OP_LOAD, 32'h0, 8'd254, 18'h00000);
        send_item(OP_LOAD, 32'h0, 8'd0, 18'h00001);
        send_item(OP_PROCESS, 32'h0001_0000, 8'd0, 18'h0);
        send_item(OP_PROCESS, 32'hFFFF_0000, 8'd0, 18'h0);
        send_item(OP_PROCESS, 32'h0000_8000, 8'd0, 18'h0);
        send_item(OP_PROCESS, 32'hFFFF_7FFF, 8'd0, 18'h0);
    endtask

    task automatic test_out_of_range();
        send_item(OP_LOAD, 32'h0, 8'hFF, 18'h3FFFF);
        send_item(OP_PROCESS, 32'h0001_0000, 8'd0, 18'h0);
    endtask

    task automatic test_center_tap();
        send_item(OP_LOAD, 32'h0, 8'd0, 18'h00000);
        send_item(OP_LOAD, 32'h0, 8'(GROUP_DELAY), 18'h1FFFF);
        send_item(OP_PROCESS, 32'h1234_5678, 8'd0, 18'h0);
    endtask

    task automatic test_back_to_back(input int n_items);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (n_items) begin
            send_item(OP_PROCESS, pick_sample($urandom_range(2)), 8'($urandom), 18'($urandom));
        end
        tx_idle_pct = 35;
        rx_idle_pct = 35;
    endtask

    task automatic test_drain_pause();
        repeat (4) send_item(OP_PROCESS, pick_sample(0), 8'($urandom), 18'($urandom));
        wait_drained();
        repeat (4) send_item(OP_PROCESS, pick_sample(1), 8'($urandom), 18'($urandom));
        wait_drained();
    endtask

    // Bursts of tap updates in one of several shapes, each followed by a burst of samples.
    task automatic test_random_fir(input int n_items);
        int          sent;
        int          profile;
        int          style;
        int          odd_off;
        logic [7:0]  idx;
        logic [17:0] val;
        sent = 0;
        while (sent < n_items) begin
            profile = $urandom_range(3);
            repeat ($urandom_range(12, 1)) begin
                idx = 8'($urandom_range(255));
                case (profile)
                    0: val = 18'($urandom);
                    1: begin
                        // Single odd-offset taps around the center, negated on the upper side.
                        odd_off = 2 * $urandom_range(31) + 1;
                        val     = 18'($urandom_range(20000));
                        if ($urandom_range(1) == 0) begin
                            idx = 8'(GROUP_DELAY + odd_off);
                            val = -val;
                        end else begin
                            idx = 8'(GROUP_DELAY - odd_off);
                        end
                    end
                    2: val = 18'h00000;
                    default: begin
                        case ($urandom_range(3))
                            0: val = 18'h1FFFF;
                            1: val = 18'h20000;
                            2: val = 18'h00001;
                            default: val = 18'h3FFFF;
                        endcase
                    end
                endcase
                send_item(OP_LOAD, $urandom, idx, val);
                sent++;
            end
            style = $urandom_range(2);
            repeat ($urandom_range(30, 5)) begin
                send_item(OP_PROCESS, pick_sample(style), 8'($urandom), 18'($urandom));
                sent++;
            end
            if ($urandom_range(9) == 0)
                wait_drained();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_start_up();
        test_coeff_extremes();
        test_rounding();
        test_out_of_range();
        test_center_tap();
        test_back_to_back(60);
        test_drain_pause();
        test_random_fir(600);
        wait_drained();
        repeat (TAPS + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* hilbert_fir_iq_split.f */
design/hfir_pkg.sv
design/hfir_cell.sv
design/hfir_ring.sv
design/hfir_mac.sv
design/hilbert_fir_iq_split.sv
tb/hilbert_fir_iq_split_tb.sv
